>>> hw/rtl/ssm_pkg.sv
// Shared types and constants for the streaming substring matcher.
// Used by ssm_step, streaming_substring_matcher, ssm_checker and tb; depends on nothing.
package ssm_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int CHAR_W      = 8;
	localparam int CNT_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int PAT_W       = MAX_PATTERN * CHAR_W;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_AT_NEWLINE = 2'd2;

	typedef enum logic [1:0] {
		ST_SEARCHING = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// Outcome of one character: status and the count to carry forward
	typedef struct packed {
		status_t            status;
		logic [CNT_W-1:0]   next_count;
	} step_res_t;

endpackage

>>> hw/rtl/ssm_step.sv
// Combinational match step: one character against the current partial match.
// Depends on ssm_pkg for widths, the status codes and the step result struct.
module ssm_step (
	input  logic [ssm_pkg::PAT_W-1:0]  pattern_bytes,
	input  logic [ssm_pkg::LEN_W-1:0]  pattern_length,
	input  logic                       stop_at_newline,
	input  logic [ssm_pkg::CHAR_W-1:0] char_in,
	input  logic                       end_of_stream,
	input  logic [ssm_pkg::CNT_W-1:0]  count,
	output ssm_pkg::step_res_t         res
);
	import ssm_pkg::*;

	logic [CHAR_W-1:0] pat [MAX_PATTERN];
	logic [LEN_W-1:0]  len_eff;
	logic [CNT_W-1:0]  m;
	logic [LEN_W-1:0]  m_inc;
	logic [CNT_W-1:0]  fb;
	// border[mm][kk]: first kk pattern bytes equal the kk bytes ending at mm-1
	logic              border [MAX_PATTERN][MAX_PATTERN];

	// Split the packed pattern into bytes
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			pat[i] = pattern_bytes[i*CHAR_W +: CHAR_W];
		end
	end

	// Clamp the length to 1..MAX_PATTERN and drop a stale count
	always_comb begin
		if (pattern_length == '0) begin
			len_eff = LEN_W'(1);
		end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = pattern_length;
		end
		m     = ({1'b0, count} >= len_eff) ? '0 : count;
		m_inc = {1'b0, m} + LEN_W'(1);
	end

	// Prefix/suffix agreement of the pattern with itself, all pairs in parallel
	always_comb begin
		for (int mm = 0; mm < MAX_PATTERN; mm++) begin
			for (int kk = 0; kk < MAX_PATTERN; kk++) begin
				border[mm][kk] = 1'b0;
				if (kk < mm) begin
					border[mm][kk] = 1'b1;
					for (int j = 0; j < kk; j++) begin
						if (pat[j] != pat[mm-kk+j]) begin
							border[mm][kk] = 1'b0;
						end
					end
				end
			end
		end
	end

	// Pick the longest fallback that the new character extends
	always_comb begin
		fb = '0;
		for (int kk = 0; kk < MAX_PATTERN - 1; kk++) begin
			if ((CNT_W'(kk) < m) && border[m][kk] && (pat[kk] == char_in)) begin
				fb = CNT_W'(kk + 1);
			end
		end
	end

	// Decide the status and the next count
	always_comb begin
		res.status     = ST_SEARCHING;
		res.next_count = '0;
		if (end_of_stream || (stop_at_newline && (char_in == NEWLINE_CHAR))) begin
			res.status = ST_NOT_FOUND;
		end else if (pat[m] == char_in) begin
			if (m_inc >= len_eff) begin
				res.status = ST_FOUND;
			end else begin
				res.next_count = m_inc[CNT_W-1:0];
			end
		end else begin
			res.next_count = fb;
		end
	end

endmodule

>>> hw/rtl/streaming_substring_matcher.sv
// Top level of the streaming substring matcher: ports, configuration
// registers, input stage and result register. Depends on ssm_pkg and ssm_step.
//
// Searches a byte stream for a pattern of one to eight bytes and returns one
// status item for every input item: 0 searching, 1 found, 2 not found. Not
// found is given for an item with tlast set (end of stream, byte ignored) or,
// when stop_at_newline is set, for a newline; after found or not found the
// match restarts. Each item passes one input register and one result register,
// and a stall on the output side can hold it in either; one item is taken
// every cycle while the output side keeps up. The whole match step,
// including the fallback over all pattern positions, is combinational logic.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// (0 pattern bytes, 1 pattern length, 2 stop at newline); the user must write
// them only while no item is in flight, as the block does not enforce it.
module streaming_substring_matcher (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ssm_pkg::PAT_W-1:0]        cfg_data,
	// input items
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // [7:0] char_in
	input  logic                             s_axis_tlast,  // end_of_stream
	// result items
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [7:0]                       m_axis_tdata   // [1:0] match_status, rest 0
);
	import ssm_pkg::*;

	logic [PAT_W-1:0]  pattern_bytes_q;
	logic [LEN_W-1:0]  pattern_length_q;
	logic              stop_at_newline_q;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eos_s1;
	logic              valid_s2;
	status_t           status_s2;
	logic [CNT_W-1:0]  matched_count_q;

	logic              adv_s2;
	logic              adv_s1;
	step_res_t         step_res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q   <= '0;
			pattern_length_q  <= LEN_W'(1);
			stop_at_newline_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PATTERN_BYTES:   pattern_bytes_q   <= cfg_data;
				CFG_PATTERN_LENGTH:  pattern_length_q  <= cfg_data[LEN_W-1:0];
				CFG_STOP_AT_NEWLINE: stop_at_newline_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Handshake: result register frees when taken, input stage when it moves on
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	ssm_step u_step (
		.pattern_bytes   (pattern_bytes_q),
		.pattern_length  (pattern_length_q),
		.stop_at_newline (stop_at_newline_q),
		.char_in         (char_s1),
		.end_of_stream   (eos_s1),
		.count           (matched_count_q),
		.res             (step_res)
	);

	// Match count advances once per item handled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matched_count_q <= '0;
		end else if (adv_s1) begin
			matched_count_q <= step_res.next_count;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_s2 <= step_res.status;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'b0, status_s2};

endmodule

>>> sim/ssm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the streaming substring matcher: watches the register port
// and both item channels, predicts each status and compares it.
// Depends on ssm_pkg for widths, register indexes and the status encoding.
module ssm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ssm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssm_pkg::PAT_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [7:0]                    m_tdata,
	output int                            waiting,
	output int                            errors
);
	import ssm_pkg::*;

	// shadow copy of the registers and of the partial match length
	logic [PAT_W-1:0] pattern;
	logic [3:0]       pat_len;
	logic             stop_nl;
	logic [CNT_W-1:0] matched;
	status_t          status_q[$];

	function automatic logic [7:0] pat_char(input int i);
		return pattern[8*i +: 8];
	endfunction

	// longest proper suffix of the matched part that is a pattern prefix
	// and is followed by c; gives the new match length, or 0
	function automatic int fall_back_len(input int m, input logic [7:0] c);
		int k;
		int j;
		bit ok;
		for (k = m - 1; k >= 0; k--) begin
			ok = (pat_char(k) == c);
			for (j = 0; j < k; j++)
				if (pat_char(j) != pat_char(m - k + j))
					ok = 1'b0;
			if (ok)
				return k + 1;
		end
		return 0;
	endfunction

	// advance the match by one character and give its status
	function automatic status_t match_char(input logic [7:0] c, input logic eos);
		int len;
		int m;
		len = (pat_len == 0) ? 1 : (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
		m = int'(matched);
		if (m >= len)
			m = 0;
		if (eos || (stop_nl && c == NEWLINE_CHAR)) begin
			matched = '0;
			return ST_NOT_FOUND;
		end
		if (pat_char(m) == c) begin
			m++;
			if (m >= len) begin
				matched = '0;
				return ST_FOUND;
			end
		end else begin
			m = fall_back_len(m, c);
		end
		matched = CNT_W'(m);
		return ST_SEARCHING;
	endfunction

	// compare results first, then queue the prediction for a new item
	always @(posedge clk or negedge arst_n) begin : watch
		status_t want;
		if (!arst_n) begin
			pattern = '0;
			pat_len = 4'd1;
			stop_nl = 1'b0;
			matched = '0;
			status_q.delete();
			waiting <= 0;
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected status item, tdata %h", $time, m_tdata);
					errors++;
				end else begin
					want = status_q.pop_front();
					if (m_tdata !== {6'b0, want}) begin
						if (errors < 10)
							$display("%0t: status mismatch: expected %0d, got tdata %h",
								$time, want, m_tdata);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready)
				status_q.push_back(match_char(s_tdata, s_tlast));
			if (cfg_we) begin
				case (cfg_index)
					CFG_PATTERN_BYTES:   pattern = cfg_data;
					CFG_PATTERN_LENGTH:  pat_len = cfg_data[3:0];
					CFG_STOP_AT_NEWLINE: stop_nl = cfg_data[0];
					default: ;
				endcase
			end
			waiting <= status_q.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Top of the streaming substring matcher testbench: clock, reset, register
// writes and character stimulus, result back-pressure and the verdict.
// Depends on ssm_pkg, streaming_substring_matcher and ssm_checker.
module tb;
	import ssm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int LONG_HOLD   = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_GOAL   = 525;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PAT_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [7:0]           m_axis_tdata;
	int                   waiting;
	int                   errors;

	// stimulus state
	logic [PAT_W-1:0] cur_pattern;
	logic [3:0]       cur_len;
	logic [7:0]       alpha [3];
	bit               burst_src;
	bit               burst_snk;
	int               holds_asked;
	int               holds_done;
	int               items_sent;
	int               cycles;

	streaming_substring_matcher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ssm_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.s_tlast   (s_axis_tlast),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.waiting   (waiting),
		.errors    (errors)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// give up at a generous cycle count
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls, occasionally one long hold-off
	initial begin : result_sink
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done != holds_asked) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			stall = burst_snk ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// offer one character item after a random gap and hold it until taken
	task automatic send_item(input logic [7:0] c, input logic eos);
		int gap;
		gap = burst_src ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eos;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// stop offering and wait until every status has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		if (idx == CFG_PATTERN_BYTES)
			cur_pattern = val;
		else if (idx == CFG_PATTERN_LENGTH)
			cur_len = val[3:0];
	endtask

	// pick new register values for one random phase
	task automatic configure_phase(input bit write_all);
		int r;
		int i;
		logic [PAT_W-1:0] pat;
		logic [PAT_W-1:0] len_word;
		alpha[0] = 8'($urandom_range(0, 255));
		alpha[1] = 8'($urandom_range(0, 255));
		alpha[2] = ($urandom_range(0, 9) == 0) ? NEWLINE_CHAR : 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 10)
			pat = '0;
		else if (r < 20)
			pat = '1;
		else if (r < 40)
			pat = {$urandom, $urandom};
		else
			for (i = 0; i < MAX_PATTERN; i++)
				pat[8*i +: 8] = alpha[($urandom_range(0, 6) == 0) ? 2 : $urandom_range(0, 1)];
		if (write_all || $urandom_range(0, 9) < 7)
			write_reg(CFG_PATTERN_BYTES, pat);
		if (write_all || $urandom_range(0, 9) < 7) begin
			len_word = {$urandom, $urandom};
			len_word[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(1, 8));
			write_reg(CFG_PATTERN_LENGTH, len_word);
		end
		if (write_all || $urandom_range(0, 9) < 5)
			write_reg(CFG_STOP_AT_NEWLINE, {$urandom, $urandom});
	endtask

	// mostly pattern prefixes, some noise, newlines and stream ends
	task automatic random_chunk();
		int r;
		int k;
		int i;
		int len;
		len = (cur_len == 0) ? 1 : (cur_len > MAX_PATTERN) ? MAX_PATTERN : int'(cur_len);
		r = $urandom_range(0, 99);
		if (r < 50) begin
			k = $urandom_range(1, len);
			for (i = 0; i < k; i++)
				send_item(cur_pattern[8*i +: 8], 1'b0);
		end else if (r < 75) begin
			send_item(alpha[$urandom_range(0, 2)], 1'b0);
		end else if (r < 87) begin
			send_item(8'($urandom_range(0, 255)), 1'b0);
		end else if (r < 94) begin
			send_item(NEWLINE_CHAR, 1'b0);
		end else begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	initial begin : stimulus
		int phase;
		int target;
		clk_init();
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_PATTERN_BYTES;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: pattern is a single zero byte
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(NEWLINE_CHAR, 1'b0);
		drain();

		// "aab" plus newline: fallback on a repeated 'a', newline stops first
		write_reg(CFG_PATTERN_BYTES, 64'h0A626161);
		write_reg(CFG_PATTERN_LENGTH, 64'd4);
		write_reg(CFG_STOP_AT_NEWLINE, 64'd1);
		send_item(8'h61, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b0);
		send_item(NEWLINE_CHAR, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b0);
		drain();
		// keep the partial match across the write, newline now completes it
		write_reg(CFG_STOP_AT_NEWLINE, 64'd0);
		send_item(NEWLINE_CHAR, 1'b0);
		drain();

		// full-length pattern of 0xFF, then length zero and length past the top
		write_reg(CFG_PATTERN_BYTES, '1);
		write_reg(CFG_PATTERN_LENGTH, 64'd8);
		repeat (8) send_item(8'hFF, 1'b0);
		drain();
		write_reg(CFG_PATTERN_LENGTH, 64'd0);
		send_item(8'hFF, 1'b0);
		drain();
		write_reg(CFG_PATTERN_LENGTH, 64'd15);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		drain();

		// random phases, a new setting each time
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			configure_phase(phase == 0);
			burst_src = ($urandom_range(0, 3) == 0);
			burst_snk = ($urandom_range(0, 3) == 0);
			if (phase == 1 || $urandom_range(0, 9) == 0) begin
				holds_asked++;
				burst_src = 1'b1;
			end
			target = items_sent + $urandom_range(20, 60);
			while (items_sent < target)
				random_chunk();
			drain();
			phase++;
		end
		burst_snk = 1'b0;

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	task automatic clk_init();
		cur_pattern = '0;
		cur_len     = 4'd1;
		burst_src   = 1'b0;
		burst_snk   = 1'b0;
		holds_asked = 0;
		holds_done  = 0;
		items_sent  = 0;
	endtask

endmodule

>>> streaming_substring_matcher.f
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_step.sv
hw/rtl/streaming_substring_matcher.sv
sim/ssm_checker.sv
sim/tb.sv
